// ----- design/lfo_tremolo_top_macros.svh -----
// ----------------------------------------------------------------------------
// lfo_tremolo_top_macros.svh
// Assertion shorthands shared by the tremolo checker.
// ----------------------------------------------------------------------------
`ifndef LFO_TREMOLO_TOP_MACROS_SVH
`define LFO_TREMOLO_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define LT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfo_tremolo check failed");

// next-cycle implication, quiet while in reset
`define LT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfo_tremolo check failed");

`endif

// ----- design/lt_pkg.sv -----
// ----------------------------------------------------------------------------
// lt_pkg
// Types, constants and the quarter-wave sine table for the tremolo block.
// ----------------------------------------------------------------------------
package lt_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int SINE_ADDR_BITS = 10;
  localparam int PHASE_BITS     = 32;

  localparam int IN_W  = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int Y_W     = 17;                // Q16, 0..65536
  localparam int DEPTH_W = 16;
  localparam int STEP_W  = 31;
  localparam int GAIN_W  = 32;                // Q31, 0..2^31
  localparam int PROD_W  = SAMPLE_BITS + GAIN_W;

  localparam logic [Y_W-1:0]     Y_ONE      = Y_W'(65536);
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(32768);

  localparam int QB      = SINE_ADDR_BITS - 2;
  localparam int QUARTER = 1 << QB;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam longint unsigned COEF_A = 64'd102944;
  localparam longint unsigned COEF_B = 64'd42048;
  localparam longint unsigned COEF_C = 64'd4640;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_SQUARE = 2'd2,
    SHAPE_NONE   = 2'd3
  } lt_shape_t;

  typedef enum logic [1:0] {
    REG_SHAPE = 2'd0,
    REG_STEP  = 2'd1,
    REG_DEPTH = 2'd2
  } lt_reg_t;

  typedef struct packed {
    lt_shape_t            shape;
    logic [STEP_W-1:0]    step;
    logic [DEPTH_W-1:0]   depth;
  } lt_cfg_t;

  // one queue entry: sample plus the oscillator value taken for it
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [Y_W-1:0]         y;
  } lt_item_t;

  typedef logic [Y_W-1:0] lt_sine_tab_t [QUARTER];

  // s = x*(A - x^2*(B - C*x^2)) over the first quarter, evaluated at elaboration
  function automatic lt_sine_tab_t sine_table();
    lt_sine_tab_t   tab;
    longint unsigned x, x2, x3, x5, s;
    for (int i = 0; i < QUARTER; i++) begin
      x  = longint'(i) << (16 - QB);
      x2 = (x * x) >> 16;
      x3 = (x2 * x) >> 16;
      x5 = (x3 * x2) >> 16;
      s  = (COEF_A * x + COEF_C * x5 - COEF_B * x3) >> 16;
      if (s > 64'd65536) s = 64'd65536;
      tab[i] = Y_W'(s);
    end
    return tab;
  endfunction

  localparam lt_sine_tab_t SINE_TAB = sine_table();

endpackage

// ----- design/lt_fifo.sv -----
// ----------------------------------------------------------------------------
// lt_fifo
// Small queue between the oscillator front end and the gain back end.
// ----------------------------------------------------------------------------
module lt_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lt_pkg::lt_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             avail,
  output lt_pkg::lt_item_t pop_item
);

  lt_pkg::lt_item_t             mem [lt_pkg::FIFO_DEPTH];
  logic [lt_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [lt_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [lt_pkg::FIFO_AW:0]     count;

  assign full     = (count == (lt_pkg::FIFO_AW+1)'(lt_pkg::FIFO_DEPTH));
  assign avail    = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/lt_front.sv -----
// ----------------------------------------------------------------------------
// lt_front
// Takes samples, runs the phase accumulator and picks the oscillator value.
// ----------------------------------------------------------------------------
module lt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  lt_pkg::lt_cfg_t                 cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lt_pkg::SAMPLE_BITS-1:0]  in_sample,
  input  logic                            in_restart,
  input  logic                            q_full,
  output logic                            q_push,
  output lt_pkg::lt_item_t                q_item
);

  localparam int PB     = lt_pkg::PHASE_BITS;
  localparam int SAB    = lt_pkg::SINE_ADDR_BITS;
  localparam int QB     = lt_pkg::QB;
  localparam int YW     = lt_pkg::Y_W;
  localparam int TRI_SH = PB - 16;
  localparam logic [PB:0]   PHASE_ONE = {1'b1, {PB{1'b0}}};
  localparam logic [PB+1:0] TRI_HALF  = (PB+2)'((64'd1 << TRI_SH) >> 1);

  logic [PB:0]     phase;
  logic [PB:0]     eff_phase;
  logic [SAB-1:0]  sin_idx;
  logic [1:0]      quad;
  logic [QB:0]     xr;
  logic [YW-1:0]   sin_s;
  logic [YW:0]     sin_sum;
  logic [PB:0]     tri_d;
  logic [PB+1:0]   tri_sum;
  logic [YW-1:0]   y;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // restart clears the phase before this sample looks at it
  assign eff_phase = in_restart ? '0 : phase;

  // sine through a quarter-wave table, mirrored and flipped by quadrant
  assign sin_idx = eff_phase[PB-1 -: SAB];
  assign quad    = sin_idx[SAB-1 -: 2];
  assign xr      = quad[0] ? ((QB+1)'(lt_pkg::QUARTER) - {1'b0, sin_idx[QB-1:0]})
                           : {1'b0, sin_idx[QB-1:0]};
  assign sin_s   = xr[QB] ? lt_pkg::Y_ONE : lt_pkg::SINE_TAB[xr[QB-1:0]];
  assign sin_sum = quad[1] ? ({1'b0, lt_pkg::Y_ONE} - {1'b0, sin_s})
                           : ({1'b0, lt_pkg::Y_ONE} + {1'b0, sin_s});

  assign tri_d   = eff_phase[PB] ? (eff_phase - PHASE_ONE) : (PHASE_ONE - eff_phase);
  assign tri_sum = {1'b0, tri_d} + TRI_HALF;

  always_comb begin
    unique case (cfg.shape)
      lt_pkg::SHAPE_SINE:   y = sin_sum[YW:1];
      lt_pkg::SHAPE_TRI:    y = tri_sum[TRI_SH +: YW];
      lt_pkg::SHAPE_SQUARE: y = eff_phase[PB] ? '0 : lt_pkg::Y_ONE;
      lt_pkg::SHAPE_NONE:   y = '0;
      default:              y = '0;
    endcase
  end

  assign q_item.sample = in_sample;
  assign q_item.y      = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (q_push) begin
      phase <= eff_phase + (PB+1)'(cfg.step);
    end
  end

endmodule

// ----- design/lt_back.sv -----
// ----------------------------------------------------------------------------
// lt_back
// Gain and sample multiply pipeline with rounding and an output register.
// ----------------------------------------------------------------------------
module lt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  lt_pkg::lt_cfg_t                 cfg,
  input  logic                            q_avail,
  input  lt_pkg::lt_item_t                q_item,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lt_pkg::SAMPLE_BITS-1:0]  out_sample
);

  localparam int SB = lt_pkg::SAMPLE_BITS;
  localparam int GW = lt_pkg::GAIN_W;
  localparam int PW = lt_pkg::PROD_W;
  localparam logic [GW:0]   GAIN_ONE   = (GW+1)'(64'd1 << 31);
  localparam logic [PW-1:0] ROUND_HALF = PW'(64'd1 << 30);

  logic [lt_pkg::DEPTH_W-1:0] depth_sat;
  logic [GW:0]                dy;
  logic [SB-1:0]              mag_in;
  logic                       st1_ready;
  logic                       st2_ready;
  logic                       out_free;

  logic                       v1;
  logic                       neg1;
  logic [SB-1:0]              mag1;
  logic [GW-1:0]              gain1;
  logic                       v2;
  logic                       neg2;
  logic [PW-1:0]              prod2;
  logic [PW-1:0]              rnd;
  logic [SB-1:0]              mag_out;

  assign out_free  = !out_valid || out_ready;
  assign st2_ready = !v2 || out_free;
  assign st1_ready = !v1 || st2_ready;
  assign q_pop     = q_avail && st1_ready;

  assign depth_sat = (cfg.depth > lt_pkg::DEPTH_FULL) ? lt_pkg::DEPTH_FULL : cfg.depth;
  assign dy        = (GW+1)'(depth_sat) * (GW+1)'(q_item.y);
  // most negative sample negates to itself, which is its magnitude unsigned
  assign mag_in    = q_item.sample[SB-1] ? (~q_item.sample + 1'b1) : q_item.sample;

  assign rnd     = prod2 + ROUND_HALF;
  assign mag_out = rnd[31 +: SB];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg1  <= q_item.sample[SB-1];
      mag1  <= mag_in;
      gain1 <= GW'(GAIN_ONE - dy);
    end
    if (st2_ready && v1) begin
      neg2  <= neg1;
      prod2 <= PW'(mag1) * PW'(gain1);
    end
    if (out_free && v2) begin
      out_sample <= neg2 ? (~mag_out + 1'b1) : mag_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (st1_ready) v1        <= q_avail;
      if (st2_ready) v2        <= v1;
      if (out_free)  out_valid <= v2;
    end
  end

endmodule

// ----- design/lfo_tremolo_top.sv -----
// ----------------------------------------------------------------------------
// lfo_tremolo_top
// Tremolo: amplitude modulation of a 24-bit audio stream by an LFO.
// ----------------------------------------------------------------------------
// Each sample is scaled by g = 1 - depth*y, y in [0,1] being the oscillator
// value at the current phase (sine, triangle, square, or none for a straight
// passthrough), then rounded half away from zero. The phase is a 33-bit
// accumulator in units of 2^-32 LFO period that advances by phase_step after every
// sample and wraps at two LFO periods; sine repeats each period, triangle and
// square every two. Setting restart with a sample zeroes the phase before
// that sample is used. Throughput is one sample per clock unless the queue
// or output stalls: the front end does one table lookup per transfer, and
// the back end is a three-stage pipeline (depth*y, |x|*g, round/sign) that
// moves one item per clock. A four-entry queue between front and back lets
// each side stall on its own. Write the configuration only while no samples
// are in flight.
// ----------------------------------------------------------------------------
module lfo_tremolo_top (
  input  logic                       clk,
  input  logic                       rst,
  // config write port
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [lt_pkg::STEP_W-1:0]  cfg_wdata,
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lt_pkg::IN_W-1:0]    s_tdata,   // [23:0] sample_in, [24] restart, rest 0
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [lt_pkg::OUT_W-1:0]   m_tdata    // [23:0] sample_out
);

  lt_pkg::lt_cfg_t                   cfg;
  lt_pkg::lt_item_t                  push_item;
  lt_pkg::lt_item_t                  pop_item;
  logic                              q_push;
  logic                              q_pop;
  logic                              q_full;
  logic                              q_avail;
  logic [lt_pkg::SAMPLE_BITS-1:0]    sample_out;

  // configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape <= lt_pkg::SHAPE_SINE;
      cfg.step  <= '0;
      cfg.depth <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lt_pkg::REG_SHAPE: cfg.shape <= lt_pkg::lt_shape_t'(cfg_wdata[1:0]);
        lt_pkg::REG_STEP:  cfg.step  <= cfg_wdata;
        lt_pkg::REG_DEPTH: cfg.depth <= cfg_wdata[lt_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // front: phase accumulator and oscillator lookup
  lt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_sample  (s_tdata[lt_pkg::SAMPLE_BITS-1:0]),
    .in_restart (s_tdata[lt_pkg::SAMPLE_BITS]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  // decoupling queue
  lt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_item  (pop_item)
  );

  // back: gain, multiply, round, output register
  lt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_avail    (q_avail),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (sample_out)
  );

  assign m_tdata = lt_pkg::OUT_W'(sample_out);

endmodule

// ----- design/lt_checker.sv -----
// ----------------------------------------------------------------------------
// lt_checker
// Port-level checks on the tremolo block, bound to the top level.
// ----------------------------------------------------------------------------
`include "lfo_tremolo_top_macros.svh"

module lt_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [lt_pkg::OUT_W-1:0]  m_tdata
);

  localparam logic [3:0] MAX_PENDING = 4'(lt_pkg::FIFO_DEPTH + 3);

  logic       in_xfer;
  logic       out_xfer;
  logic [3:0] pending;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // items taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  `LT_ASSERT_IMP(a_no_orphan_out, m_tvalid, pending != 4'd0)
  `LT_ASSERT_IMP(a_capacity, pending == MAX_PENDING, !s_tready)
  `LT_ASSERT_NEXT(a_min_latency, (pending == 4'd0) && !in_xfer, !m_tvalid)
  `LT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind lfo_tremolo_top lt_checker u_lt_checker (.*);
